/* src/mlfs_pkg.sv */
// Shared types and constants for the memory LCD frame serializer.
// No dependencies; imported by every module of the block.
package mlfs_pkg;

    localparam int MAX_LINE_BYTES_DEF = 64;

    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_TOTAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_THROUGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CMD_BITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VCOM_MASK      = 3'd4;

    localparam logic [6:0] LINE_BYTES_RST     = 7'd50;
    localparam logic [7:0] LINE_TOTAL_RST     = 8'd240;
    localparam logic       PASS_THROUGH_RST   = 1'b0;
    localparam logic [7:0] WRITE_CMD_BITS_RST = 8'h01;
    localparam logic [7:0] VCOM_MASK_RST      = 8'h02;

    localparam logic [7:0] TRAILER_BYTE = 8'h00;

    typedef struct packed {
        logic [6:0] line_bytes;
        logic [7:0] line_total;
        logic       pass_through;
        logic [7:0] write_cmd_bits;
        logic [7:0] vcom_mask;
    } mlfs_cfg_t;

    // Beats that one input byte turns into
    typedef struct packed {
        logic [7:0] cmd_byte;
        logic [7:0] addr_byte;
        logic [7:0] data_byte;
        logic       has_cmd;
        logic       has_addr;
        logic       has_trl;
        logic       has_eof;
    } mlfs_plan_t;

endpackage

/* src/memory_lcd_frame_serializer.sv */
// Memory LCD frame serializer: frame-buffer bytes in, display SPI byte stream out.
// Depends on mlfs_pkg, mlfs_cfg, mlfs_plan, mlfs_emit.
//
// Usage:
//   s_ channel carries frame-buffer bytes in raster order. Each byte turns into
//   one to five beats on the m_ channel: command byte (start of frame), line
//   address (start of line), the data byte (inverted unless pass-through),
//   a zero trailer (end of line) and a closing zero with m_tuser set (end of
//   frame). m_tlast marks the final beat caused by one input byte.
//   cfg_ channel writes the five registers; it is always ready. Write only
//   while the block is idle.
// Latency: first beat of a byte is on m_tdata the cycle after its accept.
// Throughput: one output beat per cycle while m_tready is high; an input byte
//   has 1 to 5 beats, which the single result register steps through in turn.
//   Mid-line bytes stream at one per cycle while m_tready is high.
// Reset: position counters clear, VCOM starts set, registers take their
//   defaults, no beat pending.
// Stall: a held m_tready freezes the current beat; s_tready drops until the
//   last beat of the pending byte is taken.
module memory_lcd_frame_serializer #(
    parameter int MAX_LINE_BYTES = mlfs_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] spi_byte
    output logic                            m_tlast,
    output logic                            m_tuser,   // [0] frame_end
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mlfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_data
);
    import mlfs_pkg::*;

    mlfs_cfg_t  cfg;
    mlfs_plan_t plan;
    logic       free, accept;

    assign s_tready = free;
    assign accept   = s_tvalid && s_tready;

    mlfs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mlfs_plan #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_plan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .pixel_byte (s_tdata),
        .cfg        (cfg),
        .plan       (plan)
    );

    mlfs_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .plan        (plan),
        .free        (free),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_byte      (m_tdata),
        .m_last      (m_tlast),
        .m_frame_end (m_tuser)
    );

endmodule

/* src/mlfs_cfg.sv */
// Configuration register file of the memory LCD frame serializer.
// Depends on mlfs_pkg.
module mlfs_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mlfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_data,
    output mlfs_pkg::mlfs_cfg_t             cfg
);
    import mlfs_pkg::*;

    mlfs_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_bytes     <= LINE_BYTES_RST;
            cfg_reg.line_total     <= LINE_TOTAL_RST;
            cfg_reg.pass_through   <= PASS_THROUGH_RST;
            cfg_reg.write_cmd_bits <= WRITE_CMD_BITS_RST;
            cfg_reg.vcom_mask      <= VCOM_MASK_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LINE_BYTES:     cfg_reg.line_bytes     <= cfg_data[6:0];
                CFG_LINE_TOTAL:     cfg_reg.line_total     <= cfg_data;
                CFG_PASS_THROUGH:   cfg_reg.pass_through   <= cfg_data[0];
                CFG_WRITE_CMD_BITS: cfg_reg.write_cmd_bits <= cfg_data;
                CFG_VCOM_MASK:      cfg_reg.vcom_mask      <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* src/mlfs_plan.sv */
// Line/frame position tracking and beat planning for each accepted byte.
// Depends on mlfs_pkg.
module mlfs_plan #(
    parameter int MAX_LINE_BYTES = mlfs_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           pixel_byte,
    input  mlfs_pkg::mlfs_cfg_t  cfg,
    output mlfs_pkg::mlfs_plan_t plan
);
    import mlfs_pkg::*;

    localparam int LW = $clog2(MAX_LINE_BYTES + 1);
    localparam logic [8:0] MAX_LEN = 9'(MAX_LINE_BYTES);

    logic [LW-1:0] bil_reg, bil_next, bil_inc;
    logic [7:0]    li_reg, li_next, li_inc;
    logic          vcom_reg, vcom_next;

    logic [8:0] lb_ext, eff_len;
    logic [7:0] eff_lines;
    logic       line_start, frame_start, eol, eof;

    always_comb begin
        lb_ext = {2'b00, cfg.line_bytes};
        if (lb_ext == 9'd0)
            eff_len = 9'd1;
        else if (lb_ext > MAX_LEN)
            eff_len = MAX_LEN;
        else
            eff_len = lb_ext;
        eff_lines = (cfg.line_total == 8'd0) ? 8'd1 : cfg.line_total;

        line_start  = (bil_reg == '0);
        frame_start = line_start && (li_reg == 8'd0);
        bil_inc     = bil_reg + 1'b1;
        li_inc      = li_reg + 8'd1;
        // ">=" so a shrunken length or count closes the line/frame right away
        eol = (9'(bil_inc) >= eff_len);
        eof = eol && (li_inc >= eff_lines);

        plan.cmd_byte  = cfg.write_cmd_bits | (vcom_reg ? cfg.vcom_mask : 8'h00);
        plan.addr_byte = li_inc;
        plan.data_byte = cfg.pass_through ? pixel_byte : ~pixel_byte;
        plan.has_cmd   = frame_start;
        plan.has_addr  = line_start;
        plan.has_trl   = eol;
        plan.has_eof   = eof;

        bil_next  = eol ? '0 : bil_inc;
        li_next   = eof ? 8'd0 : (eol ? li_inc : li_reg);
        vcom_next = frame_start ? ~vcom_reg : vcom_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bil_reg  <= '0;
            li_reg   <= 8'd0;
            vcom_reg <= 1'b1;
        end else if (accept) begin
            bil_reg  <= bil_next;
            li_reg   <= li_next;
            vcom_reg <= vcom_next;
        end
    end

endmodule

/* src/mlfs_emit.sv */
// Result register: holds one byte's beat plan and steps through its beats.
// Depends on mlfs_pkg.
module mlfs_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  mlfs_pkg::mlfs_plan_t plan,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_byte,
    output logic                 m_last,
    output logic                 m_frame_end
);
    import mlfs_pkg::*;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_ADDR,
        PH_DATA,
        PH_TRL,
        PH_EOF
    } phase_t;

    phase_t     phase_reg, phase_adv, phase_first;
    logic       valid_reg;
    mlfs_plan_t plan_reg;
    logic       beat_last;

    always_comb begin
        phase_adv = PH_DATA;
        beat_last = 1'b0;
        m_byte    = TRAILER_BYTE;
        unique case (phase_reg)
            PH_CMD: begin
                m_byte    = plan_reg.cmd_byte;
                phase_adv = plan_reg.has_addr ? PH_ADDR : PH_DATA;
            end
            PH_ADDR: begin
                m_byte    = plan_reg.addr_byte;
                phase_adv = PH_DATA;
            end
            PH_DATA: begin
                m_byte    = plan_reg.data_byte;
                phase_adv = PH_TRL;
                beat_last = !plan_reg.has_trl;
            end
            PH_TRL: begin
                phase_adv = PH_EOF;
                beat_last = !plan_reg.has_eof;
            end
            PH_EOF: begin
                beat_last = 1'b1;
            end
            default: ;
        endcase

        if (plan.has_cmd)
            phase_first = PH_CMD;
        else if (plan.has_addr)
            phase_first = PH_ADDR;
        else
            phase_first = PH_DATA;
    end

    assign m_valid     = valid_reg;
    assign m_last      = beat_last;
    assign m_frame_end = (phase_reg == PH_EOF);
    // next byte may enter as the final beat of the current one leaves
    assign free        = !valid_reg || (m_ready && beat_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= PH_DATA;
        end else if (load) begin
            valid_reg <= 1'b1;
            phase_reg <= phase_first;
            plan_reg  <= plan;
        end else if (valid_reg && m_ready) begin
            if (beat_last)
                valid_reg <= 1'b0;
            else
                phase_reg <= phase_adv;
        end
    end

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("loaded plan not presented");

    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_last)
        else $error("frame end beat not last of its byte");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(phase_reg) && $stable(m_byte)))
        else $error("beat changed under stall");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("plan overwritten while beats pending");

endmodule
